// ===== src/lsp_pkg.sv =====
// Shared constants, register indexes and types for the load setpoint protection block.
`timescale 1ns / 1ps
`default_nettype none
package lsp_pkg;

    localparam int PWM_PERIOD_MAX = 65535;
    localparam int ADC_BITS       = 12;

    // field widths
    localparam int OP_W       = 2;
    localparam int VCODE_W    = 12;
    localparam int SP_W       = 26;
    localparam int MV_W       = 16;
    localparam int DUTY_W     = 16;
    localparam int HEALTH_W   = 2;
    localparam int GAIN_W     = 24;
    localparam int OFFS_W     = 16;
    localparam int PWMG_W     = 32;
    localparam int LIMIT_W    = 20;
    localparam int FRAC_W     = 16;

    // stream and config port widths
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = OP_W;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // packing positions
    localparam int S_CODE_LSB   = 0;
    localparam int S_SP_LSB     = S_CODE_LSB + VCODE_W;
    localparam int M_DUTY_LSB   = 0;
    localparam int M_HEALTH_LSB = M_DUTY_LSB + DUTY_W;
    localparam int M_DRIVE_LSB  = M_HEALTH_LSB + HEALTH_W;
    localparam int M_MV_LSB     = M_DRIVE_LSB + 1;
    localparam int M_USED_W     = M_MV_LSB + MV_W;

    // datapath widths
    localparam int CAL_W      = VCODE_W + GAIN_W;
    localparam int VSUM_W     = CAL_W - FRAC_W + 2;
    localparam int DIVD_W     = 36;
    localparam int DIVR_W     = SP_W;
    localparam int DPROD_W    = PWMG_W + SP_W;
    localparam int DIV_STEPS  = LIMIT_W;
    localparam int DIVCNT_W   = $clog2(DIV_STEPS);
    localparam int THR_W      = MV_W + 2;

    localparam logic [VCODE_W-1:0] ADC_MASK =
        (ADC_BITS >= VCODE_W) ? {VCODE_W{1'b1}} : VCODE_W'((1 << ADC_BITS) - 1);

    localparam int POWER_SCALE = 1000;
    localparam int RES_SCALE   = 1000000;

    // opcodes
    localparam logic [OP_W-1:0] OP_CURRENT = 2'd0;
    localparam logic [OP_W-1:0] OP_POWER   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESIST  = 2'd2;

    // health codes
    localparam logic [HEALTH_W-1:0] HEALTH_OK = 2'd0;
    localparam logic [HEALTH_W-1:0] HEALTH_UV = 2'd1;
    localparam logic [HEALTH_W-1:0] HEALTH_OV = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OVP_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UVP_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_GAIN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 3'd6;

    // register reset values
    localparam logic [GAIN_W-1:0]  RST_VOLT_GAIN     = 24'd65536;
    localparam logic [OFFS_W-1:0]  RST_VOLT_OFFSET   = 16'd0;
    localparam logic [MV_W-1:0]    RST_OVP_LIMIT     = 16'd30000;
    localparam logic [MV_W-1:0]    RST_UVP_LIMIT     = 16'd1000;
    localparam logic [MV_W-1:0]    RST_HYSTERESIS    = 16'd100;
    localparam logic [PWMG_W-1:0]  RST_PWM_GAIN      = 32'd4295;
    localparam logic [LIMIT_W-1:0] RST_CURRENT_LIMIT = 20'd1000000;

    typedef struct packed {
        logic        [GAIN_W-1:0]  volt_gain;
        logic signed [OFFS_W-1:0]  volt_offset;
        logic        [MV_W-1:0]    ovp_limit;
        logic        [MV_W-1:0]    uvp_limit;
        logic        [MV_W-1:0]    hysteresis;
        logic        [PWMG_W-1:0]  pwm_gain;
        logic        [LIMIT_W-1:0] current_limit;
    } lsp_cfg_t;

    typedef struct packed {
        logic load;
        logic calib;
        logic volt;
        logic flag;
        logic prep;
        logic div_step;
        logic cur;
        logic mul;
        logic fin;
    } lsp_cmd_t;

    typedef struct packed {
        logic out_free;
    } lsp_stat_t;

endpackage
`default_nettype wire

// ===== src/lsp_regs.sv =====
// Configuration register file written through the config channel.
`timescale 1ns / 1ps
`default_nettype none
module lsp_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsp_pkg::CFG_DATA_W-1:0] cfg_data,
    output lsp_pkg::lsp_cfg_t                   cfg
);

    lsp_pkg::lsp_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.volt_gain     <= lsp_pkg::RST_VOLT_GAIN;
            cfg_reg.volt_offset   <= lsp_pkg::RST_VOLT_OFFSET;
            cfg_reg.ovp_limit     <= lsp_pkg::RST_OVP_LIMIT;
            cfg_reg.uvp_limit     <= lsp_pkg::RST_UVP_LIMIT;
            cfg_reg.hysteresis    <= lsp_pkg::RST_HYSTERESIS;
            cfg_reg.pwm_gain      <= lsp_pkg::RST_PWM_GAIN;
            cfg_reg.current_limit <= lsp_pkg::RST_CURRENT_LIMIT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lsp_pkg::REG_VOLT_GAIN: begin
                    cfg_reg.volt_gain <= cfg_data[lsp_pkg::GAIN_W-1:0];
                end
                lsp_pkg::REG_VOLT_OFFSET: begin
                    cfg_reg.volt_offset <= cfg_data[lsp_pkg::OFFS_W-1:0];
                end
                lsp_pkg::REG_OVP_LIMIT: begin
                    cfg_reg.ovp_limit <= cfg_data[lsp_pkg::MV_W-1:0];
                end
                lsp_pkg::REG_UVP_LIMIT: begin
                    cfg_reg.uvp_limit <= cfg_data[lsp_pkg::MV_W-1:0];
                end
                lsp_pkg::REG_HYSTERESIS: begin
                    cfg_reg.hysteresis <= cfg_data[lsp_pkg::MV_W-1:0];
                end
                lsp_pkg::REG_PWM_GAIN: begin
                    cfg_reg.pwm_gain <= cfg_data[lsp_pkg::PWMG_W-1:0];
                end
                lsp_pkg::REG_CURRENT_LIMIT: begin
                    cfg_reg.current_limit <= cfg_data[lsp_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/lsp_datapath.sv =====
// Datapath: calibration, protection flags, restoring divider, duty multiply, result register.
`timescale 1ns / 1ps
`default_nettype none
module lsp_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lsp_pkg::lsp_cfg_t             cfg,
    input  wire lsp_pkg::lsp_cmd_t             cmd,
    output lsp_pkg::lsp_stat_t                 stat,
    input  wire logic [lsp_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [lsp_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [lsp_pkg::M_TDATA_W-1:0]      m_tdata
);

    // captured item
    logic [lsp_pkg::OP_W-1:0]     op_reg;
    logic [lsp_pkg::VCODE_W-1:0]  code_reg;
    logic [lsp_pkg::SP_W-1:0]     sp_reg;

    // working registers
    logic [lsp_pkg::CAL_W-1:0]    cal_reg;
    logic [lsp_pkg::MV_W-1:0]     v_reg;
    logic [lsp_pkg::DIVD_W-1:0]   dividend_reg;
    logic [lsp_pkg::DIVR_W-1:0]   divisor_reg;
    logic [lsp_pkg::DIVR_W-1:0]   rem_reg;
    logic [lsp_pkg::LIMIT_W-1:0]  qd_reg;
    logic                         ovf_reg;
    logic [lsp_pkg::SP_W-1:0]     cur_reg;
    logic [lsp_pkg::DPROD_W-1:0]  dprod_reg;

    // persistent state
    logic                         over_reg;
    logic                         under_reg;
    logic [lsp_pkg::SP_W-1:0]     last_cur_reg;
    logic [lsp_pkg::DUTY_W-1:0]   duty_store_reg;

    // result register
    logic                         out_valid_reg;
    logic [lsp_pkg::DUTY_W-1:0]   out_duty_reg;
    logic [lsp_pkg::HEALTH_W-1:0] out_health_reg;
    logic                         out_drive_reg;
    logic [lsp_pkg::MV_W-1:0]     out_mv_reg;

    // combinational
    logic signed [lsp_pkg::VSUM_W-1:0] vsum;
    logic [lsp_pkg::MV_W-1:0]          v_next;
    logic signed [lsp_pkg::THR_W-1:0]  vs;
    logic signed [lsp_pkg::THR_W-1:0]  ovp_hi;
    logic signed [lsp_pkg::THR_W-1:0]  ovp_lo;
    logic signed [lsp_pkg::THR_W-1:0]  uvp_hi;
    logic signed [lsp_pkg::THR_W-1:0]  uvp_lo;
    logic                              over_next;
    logic                              under_next;
    logic [lsp_pkg::DIVD_W-1:0]        dividend_next;
    logic [lsp_pkg::DIVR_W-1:0]        divisor_next;
    logic [lsp_pkg::DIVR_W:0]          trial;
    logic                              trial_ge;
    logic [lsp_pkg::DIVR_W:0]          trial_diff;
    logic [lsp_pkg::SP_W-1:0]          cur_next;
    logic [lsp_pkg::DPROD_W-1:0]       dprod_next;
    logic [lsp_pkg::DPROD_W-lsp_pkg::FRAC_W-1:0] duty_wide;
    logic [lsp_pkg::DUTY_W-1:0]        duty_calc;
    logic [lsp_pkg::DUTY_W-1:0]        duty_sel;
    logic                              healthy;
    logic [lsp_pkg::HEALTH_W-1:0]      health;

    assign stat.out_free = !out_valid_reg || m_tready;

    // voltage calibration: integer part of the Q16 product plus signed offset, saturated
    always_comb begin
        vsum = $signed({2'b00, cal_reg[lsp_pkg::CAL_W-1:lsp_pkg::FRAC_W]})
             + lsp_pkg::VSUM_W'(cfg.volt_offset);
        if (vsum < 0) begin
            v_next = '0;
        end else if (vsum > $signed(lsp_pkg::VSUM_W'(2 ** lsp_pkg::MV_W - 1))) begin
            v_next = '1;
        end else begin
            v_next = vsum[lsp_pkg::MV_W-1:0];
        end
    end

    // hysteresis bounds at full signed width
    always_comb begin
        vs     = $signed({2'b00, v_reg});
        ovp_hi = $signed({2'b00, cfg.ovp_limit}) + $signed({2'b00, cfg.hysteresis});
        ovp_lo = $signed({2'b00, cfg.ovp_limit}) - $signed({2'b00, cfg.hysteresis});
        uvp_hi = $signed({2'b00, cfg.uvp_limit}) + $signed({2'b00, cfg.hysteresis});
        uvp_lo = $signed({2'b00, cfg.uvp_limit}) - $signed({2'b00, cfg.hysteresis});
        over_next  = over_reg;
        under_next = under_reg;
        if (!over_reg && (vs > ovp_hi)) begin
            over_next = 1'b1;
        end else if (over_reg && (vs <= ovp_lo)) begin
            over_next = 1'b0;
        end
        if (!under_reg && (vs < uvp_lo)) begin
            under_next = 1'b1;
        end else if (under_reg && (vs >= uvp_hi)) begin
            under_next = 1'b0;
        end
    end

    // division operands per mode
    always_comb begin
        dividend_next = '0;
        divisor_next  = '0;
        case (op_reg)
            lsp_pkg::OP_POWER: begin
                dividend_next = lsp_pkg::DIVD_W'(sp_reg)
                              * lsp_pkg::DIVD_W'(lsp_pkg::POWER_SCALE);
                divisor_next  = lsp_pkg::DIVR_W'(v_reg);
            end
            lsp_pkg::OP_RESIST: begin
                dividend_next = lsp_pkg::DIVD_W'(v_reg)
                              * lsp_pkg::DIVD_W'(lsp_pkg::RES_SCALE);
                divisor_next  = sp_reg;
            end
            default: begin
            end
        endcase
    end

    // one quotient bit per step; quotients that need more than LIMIT_W bits are caught by ovf_reg
    always_comb begin
        trial      = {rem_reg, qd_reg[lsp_pkg::LIMIT_W-1]};
        trial_ge   = trial >= {1'b0, divisor_reg};
        trial_diff = trial - {1'b0, divisor_reg};
    end

    always_comb begin
        case (op_reg)
            lsp_pkg::OP_CURRENT: begin
                cur_next = sp_reg;
            end
            lsp_pkg::OP_POWER, lsp_pkg::OP_RESIST: begin
                if ((divisor_reg == '0) || ovf_reg || (qd_reg > cfg.current_limit)) begin
                    cur_next = '0;
                end else begin
                    cur_next = lsp_pkg::SP_W'(qd_reg);
                end
            end
            default: begin
                cur_next = '0;
            end
        endcase
    end

    assign dprod_next = lsp_pkg::DPROD_W'(cfg.pwm_gain) * lsp_pkg::DPROD_W'(cur_reg);

    always_comb begin
        duty_wide = dprod_reg[lsp_pkg::DPROD_W-1:lsp_pkg::FRAC_W];
        if (duty_wide > (lsp_pkg::DPROD_W - lsp_pkg::FRAC_W)'(lsp_pkg::PWM_PERIOD_MAX)) begin
            duty_calc = lsp_pkg::DUTY_W'(lsp_pkg::PWM_PERIOD_MAX);
        end else begin
            duty_calc = duty_wide[lsp_pkg::DUTY_W-1:0];
        end
        duty_sel = (cur_reg != last_cur_reg) ? duty_calc : duty_store_reg;
        healthy  = !over_reg && !under_reg;
        if (under_reg) begin
            health = lsp_pkg::HEALTH_UV;
        end else if (over_reg) begin
            health = lsp_pkg::HEALTH_OV;
        end else begin
            health = lsp_pkg::HEALTH_OK;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            over_reg       <= 1'b0;
            under_reg      <= 1'b0;
            last_cur_reg   <= '0;
            duty_store_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.flag) begin
                over_reg  <= over_next;
                under_reg <= under_next;
            end
            if (cmd.fin && healthy) begin
                last_cur_reg   <= cur_reg;
                duty_store_reg <= duty_sel;
            end
            if (cmd.fin) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_tuser;
            code_reg <= s_tdata[lsp_pkg::S_CODE_LSB +: lsp_pkg::VCODE_W];
            sp_reg   <= s_tdata[lsp_pkg::S_SP_LSB +: lsp_pkg::SP_W];
        end
        if (cmd.calib) begin
            cal_reg <= lsp_pkg::CAL_W'(code_reg & lsp_pkg::ADC_MASK)
                     * lsp_pkg::CAL_W'(cfg.volt_gain);
        end
        if (cmd.volt) begin
            v_reg <= v_next;
        end
        if (cmd.flag) begin
            dividend_reg <= dividend_next;
            divisor_reg  <= divisor_next;
        end
        if (cmd.prep) begin
            rem_reg <= lsp_pkg::DIVR_W'(dividend_reg[lsp_pkg::DIVD_W-1:lsp_pkg::LIMIT_W]);
            qd_reg  <= dividend_reg[lsp_pkg::LIMIT_W-1:0];
            ovf_reg <= lsp_pkg::DIVR_W'(dividend_reg[lsp_pkg::DIVD_W-1:lsp_pkg::LIMIT_W])
                       >= divisor_reg;
        end
        if (cmd.div_step) begin
            rem_reg <= trial_ge ? trial_diff[lsp_pkg::DIVR_W-1:0]
                                : trial[lsp_pkg::DIVR_W-1:0];
            qd_reg  <= {qd_reg[lsp_pkg::LIMIT_W-2:0], trial_ge};
        end
        if (cmd.cur) begin
            cur_reg <= cur_next;
        end
        if (cmd.mul) begin
            dprod_reg <= dprod_next;
        end
        if (cmd.fin) begin
            out_duty_reg   <= healthy ? duty_sel : '0;
            out_health_reg <= health;
            out_drive_reg  <= healthy && (cur_reg != '0);
            out_mv_reg     <= v_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    always_comb begin
        m_tdata = '0;
        m_tdata[lsp_pkg::M_DUTY_LSB +: lsp_pkg::DUTY_W]     = out_duty_reg;
        m_tdata[lsp_pkg::M_HEALTH_LSB +: lsp_pkg::HEALTH_W] = out_health_reg;
        m_tdata[lsp_pkg::M_DRIVE_LSB]                       = out_drive_reg;
        m_tdata[lsp_pkg::M_MV_LSB +: lsp_pkg::MV_W]         = out_mv_reg;
    end

endmodule
`default_nettype wire

// ===== src/lsp_ctrl.sv =====
// Sequencer that steps the datapath through one item at a time.
`timescale 1ns / 1ps
`default_nettype none
module lsp_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire lsp_pkg::lsp_stat_t stat,
    output lsp_pkg::lsp_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CALIB = 4'd1;
    localparam logic [3:0] S_VOLT  = 4'd2;
    localparam logic [3:0] S_FLAG  = 4'd3;
    localparam logic [3:0] S_PREP  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_CUR   = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]                     state_reg;
    logic [3:0]                     state_next;
    logic [lsp_pkg::DIVCNT_W-1:0]   cnt_reg;
    logic [lsp_pkg::DIVCNT_W-1:0]   cnt_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CALIB;
                end
            end
            S_CALIB: begin
                cmd.calib  = 1'b1;
                state_next = S_VOLT;
            end
            S_VOLT: begin
                cmd.volt   = 1'b1;
                state_next = S_FLAG;
            end
            S_FLAG: begin
                cmd.flag   = 1'b1;
                state_next = S_PREP;
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == lsp_pkg::DIVCNT_W'(lsp_pkg::DIV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_CUR;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_CUR: begin
                cmd.cur    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                // hold until the result register is free or drains this cycle
                if (stat.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/load_setpoint_protection_top.sv =====
// Items are processed one at a time: each steps through the calibrate, voltage, flag,
// prepare, divide, current, multiply and finish states, the divide state running the
// 20-step restoring divider (one quotient bit per cycle).
// A new item is taken while the previous result waits in the output register.
// Reset (aresetn low, synchronous) clears the protection flags, last current,
// stored duty and result valid, and loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none
module load_setpoint_protection_top (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [11:0] voltage_code, [37:12] setpoint, [39:38] zero
    input  wire logic [lsp_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] opcode
    input  wire logic [lsp_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [15:0] duty, [17:16] health, [18] drive_enable, [34:19] voltage_mv, [39:35] zero
    output logic [lsp_pkg::M_TDATA_W-1:0]       m_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsp_pkg::CFG_DATA_W-1:0] cfg_data
);

    lsp_pkg::lsp_cfg_t  cfg;
    lsp_pkg::lsp_cmd_t  cmd;
    lsp_pkg::lsp_stat_t stat;

    lsp_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lsp_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// ===== src/lsp_checker.sv =====
// Port-level assertions for the top level and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
module lsp_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [lsp_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a fault forces duty and drive to zero
    a_fault_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[lsp_pkg::M_HEALTH_LSB +: lsp_pkg::HEALTH_W] != lsp_pkg::HEALTH_OK)
        |-> (m_tdata[lsp_pkg::M_DUTY_LSB +: lsp_pkg::DUTY_W] == '0)
            && !m_tdata[lsp_pkg::M_DRIVE_LSB])
        else $error("duty or drive active during fault");

    // one item at a time: after an input transaction the input side closes
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    // no result can appear on the cycle right after an input transaction
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind load_setpoint_protection_top lsp_checker u_lsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for load_setpoint_protection_top: directed table, then random phases.
`timescale 1ns / 1ps
module tb;
    import lsp_pkg::*;

    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRINTS   = 100;

    typedef enum logic [0:0] {ROW_ITEM, ROW_REG} row_kind_e;
    typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_RARELY, RDY_BURSTY} ready_mode_e;
    typedef enum int {CFG_NOMINAL, CFG_WILD, CFG_EXTREME} cfg_profile_e;

    typedef struct packed {
        logic [DUTY_W-1:0]   duty;
        logic [HEALTH_W-1:0] health;
        logic                drive;
        logic [MV_W-1:0]     mv;
    } load_out_t;

    typedef struct packed {
        row_kind_e             kind;
        logic [OP_W-1:0]       op;
        logic [VCODE_W-1:0]    code;
        logic [SP_W-1:0]       sp;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  typed;
        load_out_t             want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    load_setpoint_protection_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state and register shadow
    lsp_cfg_t  shadow;
    logic      over_flag;
    logic      under_flag;
    longint    last_current;
    logic [DUTY_W-1:0] duty_store;

    load_out_t pending_outputs[$];
    stim_row_t directed_rows[$];
    int        mismatch_count;
    int        outputs_seen;
    int        burst_left;
    load_out_t mon_got;
    load_out_t mon_want;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #25_000_000;
        $display("load_setpoint_protection_top regression: fail");
        $finish;
    end

    function automatic longint calib_mv(logic [VCODE_W-1:0] code);
        longint v;
        v = (longint'(code & ADC_MASK) * longint'(shadow.volt_gain)) >>> FRAC_W;
        v = v + longint'($signed(shadow.volt_offset));
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v;
    endfunction

    function automatic load_out_t predict_load_output(logic [OP_W-1:0] op,
                                                      logic [VCODE_W-1:0] code,
                                                      logic [SP_W-1:0] sp);
        load_out_t r;
        longint    mv;
        longint    hyst;
        longint    cur;
        longint    d;
        r = '0;
        mv = calib_mv(code);
        hyst = longint'(shadow.hysteresis);
        if (!over_flag && mv > longint'(shadow.ovp_limit) + hyst) over_flag = 1'b1;
        else if (over_flag && mv <= longint'(shadow.ovp_limit) - hyst) over_flag = 1'b0;
        if (!under_flag && mv < longint'(shadow.uvp_limit) - hyst) under_flag = 1'b1;
        else if (under_flag && mv >= longint'(shadow.uvp_limit) + hyst) under_flag = 1'b0;
        r.health = under_flag ? HEALTH_UV : (over_flag ? HEALTH_OV : HEALTH_OK);

        case (op)
            OP_CURRENT: cur = longint'(sp);
            OP_POWER: begin
                cur = (mv == 0) ? 0 : longint'(sp) * POWER_SCALE / mv;
                if (cur > longint'(shadow.current_limit)) cur = 0;
            end
            OP_RESIST: begin
                cur = (sp == '0) ? 0 : mv * RES_SCALE / longint'(sp);
                if (cur > longint'(shadow.current_limit)) cur = 0;
            end
            default: cur = 0;
        endcase

        // duty only recomputed on a new current; held values survive a fault
        if (r.health == HEALTH_OK) begin
            if (cur != last_current) begin
                d = (longint'(shadow.pwm_gain) * cur) >>> FRAC_W;
                if (d > PWM_PERIOD_MAX) d = PWM_PERIOD_MAX;
                duty_store = d[DUTY_W-1:0];
            end
            last_current = cur;
            r.duty = duty_store;
            r.drive = (cur > 0);
        end
        r.mv = mv[MV_W-1:0];
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] cfg_value(cfg_profile_e p,
                                                        logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] v;
        logic                  hi;
        v = $urandom;
        hi = $urandom_range(0, 1);
        if (p == CFG_NOMINAL) begin
            case (idx)
                REG_VOLT_GAIN:   v = $urandom_range(40000, 120000);
                REG_VOLT_OFFSET: v = 32'(int'($urandom_range(0, 400)) - 200);
                REG_OVP_LIMIT:   v = $urandom_range(2000, 5000);
                REG_UVP_LIMIT:   v = $urandom_range(0, 1500);
                REG_HYSTERESIS:  v = $urandom_range(0, 300);
                REG_PWM_GAIN:    v = ($urandom_range(0, 3) == 0) ? $urandom
                                                                 : $urandom_range(500, 200000);
                REG_CURRENT_LIMIT: v = ($urandom_range(0, 3) == 0) ? $urandom
                                                                   : $urandom_range(1000, 1048575);
                default: ;
            endcase
        end else if (p == CFG_EXTREME) begin
            case (idx)
                REG_VOLT_GAIN:     v = hi ? 32'hFF_FFFF : 32'h0;
                REG_VOLT_OFFSET:   v = hi ? 32'h7FFF : 32'h8000;
                REG_OVP_LIMIT:     v = hi ? 32'hFFFF : 32'h0;
                REG_UVP_LIMIT:     v = hi ? 32'hFFFF : 32'h0;
                REG_HYSTERESIS:    v = hi ? 32'hFFFF : 32'h0;
                REG_PWM_GAIN:      v = hi ? 32'hFFFF_FFFF : 32'h0;
                REG_CURRENT_LIMIT: v = hi ? 32'hF_FFFF : 32'h0;
                default: ;
            endcase
        end
        return v;
    endfunction

    function automatic void add_item(logic [OP_W-1:0] op, logic [VCODE_W-1:0] code,
                                     logic [SP_W-1:0] sp);
        stim_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.op = op;
        row.code = code;
        row.sp = sp;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(logic [OP_W-1:0] op, logic [VCODE_W-1:0] code,
                                        logic [SP_W-1:0] sp, logic [DUTY_W-1:0] duty,
                                        logic [HEALTH_W-1:0] health, logic drive,
                                        logic [MV_W-1:0] mv);
        stim_row_t row;
        row = '0;
        row.kind = ROW_ITEM;
        row.op = op;
        row.code = code;
        row.sp = sp;
        row.typed = 1'b1;
        row.want.duty = duty;
        row.want.health = health;
        row.want.drive = drive;
        row.want.mv = mv;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.idx = idx;
        row.data = data;
        directed_rows.push_back(row);
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // burst/gap pacing of the input stream; called at a falling edge
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [VCODE_W-1:0] code,
                             input logic [SP_W-1:0] sp, input logic typed,
                             input load_out_t want);
        logic [S_TDATA_W-1:0] word;
        load_out_t            predicted;
        word = '0;
        word[S_CODE_LSB +: VCODE_W] = code;
        word[S_SP_LSB +: SP_W] = sp;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_load_output(op, code, sp);
        pending_outputs.push_back(typed ? want : predicted);
        @(negedge aclk);
        pace();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_VOLT_GAIN:     shadow.volt_gain = data[GAIN_W-1:0];
            REG_VOLT_OFFSET:   shadow.volt_offset = data[OFFS_W-1:0];
            REG_OVP_LIMIT:     shadow.ovp_limit = data[MV_W-1:0];
            REG_UVP_LIMIT:     shadow.uvp_limit = data[MV_W-1:0];
            REG_HYSTERESIS:    shadow.hysteresis = data[MV_W-1:0];
            REG_PWM_GAIN:      shadow.pwm_gain = data[PWMG_W-1:0];
            REG_CURRENT_LIMIT: shadow.current_limit = data[LIMIT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // stop both request streams and wait for every outstanding result
    task automatic drain();
        if (s_tvalid) s_tvalid <= 1'b0;
        if (cfg_valid) cfg_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // receiver back-pressure
    initial begin
        ready_mode_e ready_mode;
        int          span;
        int          ready_tick;
        m_tready = 1'b0;
        ready_tick = 0;
        forever begin
            ready_mode = ready_mode_e'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge aclk);
                ready_tick++;
                case (ready_mode)
                    RDY_ALWAYS: m_tready <= 1'b1;
                    RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                    RDY_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
                    default:    m_tready <= ((ready_tick % 40) < 8);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_got.duty = m_tdata[M_DUTY_LSB +: DUTY_W];
            mon_got.health = m_tdata[M_HEALTH_LSB +: HEALTH_W];
            mon_got.drive = m_tdata[M_DRIVE_LSB];
            mon_got.mv = m_tdata[M_MV_LSB +: MV_W];
            if (pending_outputs.size() == 0) begin
                flag_mismatch($sformatf("output %0d arrived with no item pending", outputs_seen));
            end else begin
                mon_want = pending_outputs.pop_front();
                if (mon_got.duty !== mon_want.duty)
                    flag_mismatch($sformatf("output %0d duty: got %0d, expected %0d",
                                            outputs_seen, mon_got.duty, mon_want.duty));
                if (mon_got.health !== mon_want.health)
                    flag_mismatch($sformatf("output %0d health: got %0d, expected %0d",
                                            outputs_seen, mon_got.health, mon_want.health));
                if (mon_got.drive !== mon_want.drive)
                    flag_mismatch($sformatf("output %0d drive_enable: got %0d, expected %0d",
                                            outputs_seen, mon_got.drive, mon_want.drive));
                if (mon_got.mv !== mon_want.mv)
                    flag_mismatch($sformatf("output %0d voltage_mv: got %0d, expected %0d",
                                            outputs_seen, mon_got.mv, mon_want.mv));
            end
            outputs_seen++;
        end
    end

    initial begin
        logic [OP_W-1:0]    op;
        logic [VCODE_W-1:0] code;
        logic [SP_W-1:0]    sp;
        logic               have_prev;
        cfg_profile_e       profile;
        longint             mv;
        longint             target;
        longint             c;
        longint             tgt_cur;
        longint             spv;
        int                 pick;
        int                 phase_len;
        int                 items_sent;

        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        aresetn = 1'b0;
        mismatch_count = 0;
        outputs_seen = 0;
        burst_left = 0;
        have_prev = 1'b0;
        items_sent = 0;
        op = OP_CURRENT;
        code = '0;
        sp = '0;

        shadow.volt_gain = RST_VOLT_GAIN;
        shadow.volt_offset = RST_VOLT_OFFSET;
        shadow.ovp_limit = RST_OVP_LIMIT;
        shadow.uvp_limit = RST_UVP_LIMIT;
        shadow.hysteresis = RST_HYSTERESIS;
        shadow.pwm_gain = RST_PWM_GAIN;
        shadow.current_limit = RST_CURRENT_LIMIT;
        over_flag = 1'b0;
        under_flag = 1'b0;
        last_current = 0;
        duty_store = '0;

        // defaults after reset: unity gain, so voltage_mv equals the code
        add_checked(OP_CURRENT, 12'd0, 26'd12345, 16'd0, HEALTH_UV, 1'b0, 16'd0);
        add_checked(OP_CURRENT, 12'd4095, 26'd0, 16'd0, HEALTH_OK, 1'b0, 16'd4095);
        add_item(OP_CURRENT, 12'd4095, 26'd1000);
        add_item(OP_CURRENT, 12'd4095, 26'd1000);      // same current, duty held
        add_checked(OP_CURRENT, 12'd2000, '1, 16'hFFFF, HEALTH_OK, 1'b1, 16'd2000);
        add_reg(REG_UVP_LIMIT, 32'd0);
        add_reg(REG_HYSTERESIS, 32'd0);
        add_checked(OP_POWER, 12'd0, 26'd5000, 16'd0, HEALTH_OK, 1'b0, 16'd0);
        add_item(OP_POWER, 12'd3000, 26'd3000000);     // exactly at the limit
        add_item(OP_POWER, 12'd3000, 26'd3000003);     // just above the limit
        add_item(OP_RESIST, 12'd1234, 26'd0);
        add_item(OP_RESIST, 12'd1000, 26'd1000);
        add_item(OP_RESIST, 12'd1000, 26'd999);
        add_item(OP_RESIST, 12'd4095, '1);
        add_item(OP_UNUSED, 12'd2000, 26'd777);
        add_item(OP_POWER, 12'd4095, '1);
        add_reg(REG_VOLT_GAIN, 32'hFF_FFFF);
        add_reg(REG_VOLT_OFFSET, 32'h7FFF);
        add_checked(OP_CURRENT, 12'd4095, 26'd500, 16'd0, HEALTH_OV, 1'b0, 16'hFFFF);
        add_reg(REG_VOLT_GAIN, 32'd0);
        add_reg(REG_VOLT_OFFSET, 32'h8000);
        add_reg(REG_PWM_GAIN, 32'hFFFF_FFFF);
        add_reg(REG_CURRENT_LIMIT, 32'hF_FFFF);
        add_reg(REG_UNUSED, 32'hFFFF_FFFF);
        add_item(OP_CURRENT, 12'd100, 26'd1);
        add_item(OP_POWER, 12'd100, 26'd5);
        // hysteresis bands around 3000 and 1000 mV
        add_reg(REG_VOLT_GAIN, 32'd65536);
        add_reg(REG_VOLT_OFFSET, 32'd0);
        add_reg(REG_OVP_LIMIT, 32'd3000);
        add_reg(REG_UVP_LIMIT, 32'd1000);
        add_reg(REG_HYSTERESIS, 32'd200);
        add_reg(REG_PWM_GAIN, 32'(RST_PWM_GAIN));
        add_reg(REG_CURRENT_LIMIT, 32'(RST_CURRENT_LIMIT));
        add_item(OP_CURRENT, 12'd3200, 26'd5000);
        add_item(OP_CURRENT, 12'd3201, 26'd5001);
        add_item(OP_CURRENT, 12'd2801, 26'd5002);
        add_item(OP_CURRENT, 12'd2800, 26'd5003);
        add_item(OP_CURRENT, 12'd801, 26'd5004);
        add_item(OP_CURRENT, 12'd799, 26'd5005);
        add_item(OP_CURRENT, 12'd1199, 26'd5006);
        add_item(OP_CURRENT, 12'd1200, 26'd5007);
        // both flags set at once: under-voltage wins
        add_reg(REG_OVP_LIMIT, 32'd1000);
        add_reg(REG_UVP_LIMIT, 32'd5000);
        add_reg(REG_HYSTERESIS, 32'd0);
        add_item(OP_CURRENT, 12'd3000, 26'd400);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < directed_rows.size(); i++) begin
            if (directed_rows[i].kind == ROW_REG) begin
                drain();
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end else begin
                if (cfg_valid) cfg_valid <= 1'b0;
                send_item(directed_rows[i].op, directed_rows[i].code, directed_rows[i].sp,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        while (items_sent < RANDOM_ITEMS) begin
            drain();
            pick = $urandom_range(0, 9);
            profile = (pick < 6) ? CFG_NOMINAL : ((pick < 8) ? CFG_WILD : CFG_EXTREME);
            for (int k = REG_VOLT_GAIN; k <= REG_CURRENT_LIMIT; k++)
                write_reg(k[CFG_IDX_W-1:0], cfg_value(profile, k[CFG_IDX_W-1:0]));
            if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom);
            have_prev = 1'b0;

            phase_len = $urandom_range(40, 160);
            repeat (phase_len) begin
                // a repeated item keeps the current, so the stored duty must be reused
                if (!(have_prev && $urandom_range(0, 4) == 0)) begin
                    pick = $urandom_range(0, 15);
                    op = (pick < 5) ? OP_CURRENT : (pick < 10) ? OP_POWER
                       : (pick < 15) ? OP_RESIST : OP_UNUSED;
                    case ($urandom_range(0, 7))
                        0: code = '0;
                        1: code = '1;
                        2, 3: begin
                            case ($urandom_range(0, 3))
                                0: target = longint'(shadow.ovp_limit) + longint'(shadow.hysteresis);
                                1: target = longint'(shadow.ovp_limit) - longint'(shadow.hysteresis);
                                2: target = longint'(shadow.uvp_limit) - longint'(shadow.hysteresis);
                                default: target = longint'(shadow.uvp_limit)
                                                + longint'(shadow.hysteresis);
                            endcase
                            target = target + longint'(int'($urandom_range(0, 4)) - 2);
                            if (shadow.volt_gain == '0) begin
                                code = $urandom;
                            end else begin
                                c = (((target - longint'($signed(shadow.volt_offset))) <<< FRAC_W)
                                     + longint'(shadow.volt_gain) - 1) / longint'(shadow.volt_gain);
                                if (c < 0) c = 0;
                                if (c > longint'(ADC_MASK)) c = longint'(ADC_MASK);
                                code = c[VCODE_W-1:0];
                            end
                        end
                        default: code = $urandom;
                    endcase

                    mv = calib_mv(code);
                    if ($urandom_range(0, 1) == 0)
                        tgt_cur = longint'(shadow.current_limit)
                                + longint'(int'($urandom_range(0, 4)) - 2);
                    else
                        tgt_cur = longint'($urandom_range(0, shadow.current_limit));
                    case (op)
                        OP_POWER:  spv = tgt_cur * mv / POWER_SCALE
                                       + longint'($urandom_range(0, 2));
                        OP_RESIST: spv = (tgt_cur <= 0) ? 0 : mv * RES_SCALE / tgt_cur;
                        default:   spv = longint'($urandom_range(0, 1048575));
                    endcase
                    if (spv < 0) spv = 0;
                    sp = (spv > longint'({SP_W{1'b1}})) ? '1 : spv[SP_W-1:0];
                    pick = $urandom_range(0, 15);
                    if (pick < 3) sp = $urandom;
                    else if (pick == 3) sp = '0;
                    else if (pick == 4) sp = '1;
                    have_prev = 1'b1;
                end
                if (cfg_valid) cfg_valid <= 1'b0;
                send_item(op, code, sp, 1'b0, '0);
                items_sent++;
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_outputs.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_outputs.size()));
        if (mismatch_count == 0)
            $display("load_setpoint_protection_top regression: pass");
        else
            $display("load_setpoint_protection_top regression: fail");
        $finish;
    end

endmodule

// ===== load_setpoint_protection_top.f =====
src/lsp_pkg.sv
src/lsp_regs.sv
src/lsp_datapath.sv
src/lsp_ctrl.sv
src/load_setpoint_protection_top.sv
src/lsp_checker.sv
sim/tb.sv
